// ----- rtl/entc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// entc_pkg
// shared types and constants for the nearest-target elevator controller
// ----------------------------------------------------------------------------
package entc_pkg;

    localparam int FLOOR_W     = 4;
    localparam int FLOOR_SLOTS = 1 << FLOOR_W;
    localparam int NUM_FLOORS  = 16;
    localparam int RESET_FLOOR = 0;

    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_STOP    = 2'd2;
    localparam logic [1:0] OP_START   = 2'd3;

    localparam logic [1:0] MOT_IDLE = 2'd0;
    localparam logic [1:0] MOT_UP   = 2'd1;
    localparam logic [1:0] MOT_DOWN = 2'd2;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_DOORS = 2'd1;
    localparam logic [1:0] ACT_UP    = 2'd2;
    localparam logic [1:0] ACT_DOWN  = 2'd3;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } dp_status_t;

endpackage : entc_pkg
`default_nettype wire

// ----- rtl/entc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// entc_ctrl
// sequencer: capture, serial floor scan, commit into the output register
// ----------------------------------------------------------------------------
module entc_ctrl
    import entc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!status.need_scan)
                begin
                    state_next = ST_APPLY;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    if (status.scan_last)
                    begin
                        state_next = ST_APPLY;
                    end
                end
            end
            ST_APPLY:
            begin
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule : entc_ctrl
`default_nettype wire

// ----- rtl/entc_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// entc_datapath
// car state, nearest-floor scan unit and result register
// ----------------------------------------------------------------------------
module entc_datapath
    import entc_pkg::*;
#(
    parameter int NUM_FLOORS  = entc_pkg::NUM_FLOORS,
    parameter int RESET_FLOOR = entc_pkg::RESET_FLOOR
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctrl_cmd_t          cmd,
    output dp_status_t              status,
    input  wire logic [1:0]         operation,
    input  wire logic [FLOOR_W-1:0] request_floor,
    output logic [FLOOR_W-1:0]      car_floor,
    output logic [1:0]              motion_state,
    output logic [1:0]              step_action,
    output logic [FLOOR_W-1:0]      chosen_target,
    output logic                    target_valid,
    output logic                    car_idle,
    output logic                    request_rejected,
    output logic                    is_running
);

    localparam logic [FLOOR_W:0] DIST_NONE = '1;
    localparam logic [FLOOR_W-1:0] LAST_IDX = FLOOR_W'(FLOOR_SLOTS - 1);

    // captured transaction
    logic [1:0]         op_reg;
    logic [FLOOR_W-1:0] req_reg;

    // car state
    logic [FLOOR_SLOTS-1:0] pending_reg, pending_next;
    logic [FLOOR_W-1:0]     floor_reg, floor_next;
    logic [1:0]             motion_reg, motion_next;
    logic                   run_reg, run_next;

    // scan unit
    logic [FLOOR_W-1:0] idx_reg;
    logic [FLOOR_W-1:0] best_reg;
    logic [FLOOR_W:0]   best_dist_reg;
    logic               found_reg;
    logic [FLOOR_W-1:0] slot_dist;
    logic               closer;

    // result register
    logic [FLOOR_W-1:0] car_floor_reg;
    logic [1:0]         motion_state_reg;
    logic [1:0]         step_action_reg;
    logic [FLOOR_W-1:0] chosen_target_reg;
    logic               target_valid_reg;
    logic               car_idle_reg;
    logic               request_rejected_reg;
    logic               is_running_reg;

    logic [1:0]         action_next;
    logic [FLOOR_W-1:0] chosen_next;
    logic               valid_next;
    logic               rejected_next;

    assign status.need_scan = (op_reg == OP_TICK) && run_reg;
    assign status.scan_last = (idx_reg == LAST_IDX);

    assign slot_dist = (idx_reg > floor_reg) ? (idx_reg - floor_reg) : (floor_reg - idx_reg);
    assign closer    = pending_reg[idx_reg] && ({1'b0, slot_dist} < best_dist_reg);

    always_comb
    begin
        pending_next  = pending_reg;
        floor_next    = floor_reg;
        motion_next   = motion_reg;
        run_next      = run_reg;
        action_next   = ACT_NONE;
        chosen_next   = '0;
        valid_next    = 1'b0;
        rejected_next = 1'b0;
        unique case (op_reg)
            OP_REQUEST:
            begin
                if (7'(req_reg) < 7'(NUM_FLOORS))
                begin
                    pending_next = pending_reg | (FLOOR_SLOTS'(1) << req_reg);
                end
                else
                begin
                    rejected_next = 1'b1;
                end
            end
            OP_TICK:
            begin
                if (run_reg && found_reg)
                begin
                    chosen_next = best_reg;
                    valid_next  = 1'b1;
                    if (best_reg == floor_reg)
                    begin
                        pending_next = pending_reg & ~(FLOOR_SLOTS'(1) << best_reg);
                        motion_next  = MOT_IDLE;
                        action_next  = ACT_DOORS;
                    end
                    else if (best_reg > floor_reg)
                    begin
                        motion_next = MOT_UP;
                        floor_next  = floor_reg + 1'b1;
                        action_next = ACT_UP;
                    end
                    else
                    begin
                        motion_next = MOT_DOWN;
                        floor_next  = floor_reg - 1'b1;
                        action_next = ACT_DOWN;
                    end
                    if (pending_next == '0)
                    begin
                        motion_next = MOT_IDLE;
                    end
                end
            end
            OP_STOP:
            begin
                run_next = 1'b0;
            end
            OP_START:
            begin
                run_next = 1'b1;
            end
            default:
            begin
                run_next = run_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            floor_reg   <= FLOOR_W'(RESET_FLOOR);
            motion_reg  <= MOT_IDLE;
            run_reg     <= 1'b0;
        end
        else if (cmd.commit)
        begin
            pending_reg <= pending_next;
            floor_reg   <= floor_next;
            motion_reg  <= motion_next;
            run_reg     <= run_next;
        end
    end

    // capture and scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= OP_REQUEST;
            req_reg       <= '0;
            idx_reg       <= '0;
            best_reg      <= '0;
            best_dist_reg <= DIST_NONE;
            found_reg     <= 1'b0;
        end
        else if (cmd.load)
        begin
            op_reg        <= operation;
            req_reg       <= request_floor;
            idx_reg       <= '0;
            best_reg      <= '0;
            best_dist_reg <= DIST_NONE;
            found_reg     <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (closer)
            begin
                best_reg      <= idx_reg;
                best_dist_reg <= {1'b0, slot_dist};
                found_reg     <= 1'b1;
            end
        end
    end

    // result register, written only when the output slot is free
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            car_floor_reg        <= floor_next;
            motion_state_reg     <= motion_next;
            step_action_reg      <= action_next;
            chosen_target_reg    <= chosen_next;
            target_valid_reg     <= valid_next;
            car_idle_reg         <= (motion_next == MOT_IDLE) && (pending_next == '0);
            request_rejected_reg <= rejected_next;
            is_running_reg       <= run_next;
        end
    end

    assign car_floor        = car_floor_reg;
    assign motion_state     = motion_state_reg;
    assign step_action      = step_action_reg;
    assign chosen_target    = chosen_target_reg;
    assign target_valid     = target_valid_reg;
    assign car_idle         = car_idle_reg;
    assign request_rejected = request_rejected_reg;
    assign is_running       = is_running_reg;

endmodule : entc_datapath
`default_nettype wire

// ----- rtl/elevator_nearest_target_controller_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// elevator_nearest_target_controller_top
// single-car elevator controller with nearest pending floor selection
// ----------------------------------------------------------------------------
// one transaction at a time: a tick taken while running scans all sixteen
// floor slots and then commits its result into the output register;
// request, stop and start skip the scan, as does a tick while stopped.
// the next input is accepted in the cycle after commit.
// the scan comparator visits one floor per cycle.
// results sit in an output register, so the next input is accepted while the
// previous result waits; commit stalls only while that register is full and
// out_ready is low
// ----------------------------------------------------------------------------
module elevator_nearest_target_controller_top
    import entc_pkg::*;
#(
    parameter int NUM_FLOORS  = entc_pkg::NUM_FLOORS,
    parameter int RESET_FLOOR = entc_pkg::RESET_FLOOR
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input channel
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         operation,
    input  wire logic [FLOOR_W-1:0] request_floor,
    // output channel
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [FLOOR_W-1:0]      car_floor,
    output logic [1:0]              motion_state,
    output logic [1:0]              step_action,
    output logic [FLOOR_W-1:0]      chosen_target,
    output logic                    target_valid,
    output logic                    car_idle,
    output logic                    request_rejected,
    output logic                    is_running
);

    // command and status between sequencer and datapath
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer: idle, scan, apply
    entc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // car state, scan unit and result register
    entc_datapath #(
        .NUM_FLOORS  (NUM_FLOORS),
        .RESET_FLOOR (RESET_FLOOR)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .operation        (operation),
        .request_floor    (request_floor),
        .car_floor        (car_floor),
        .motion_state     (motion_state),
        .step_action      (step_action),
        .chosen_target    (chosen_target),
        .target_valid     (target_valid),
        .car_idle         (car_idle),
        .request_rejected (request_rejected),
        .is_running       (is_running)
    );

endmodule : elevator_nearest_target_controller_top
`default_nettype wire

// ----- rtl/entc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// entc_checker
// port-level checks for the elevator controller, bound to the top level
// ----------------------------------------------------------------------------
module entc_checker
    import entc_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [FLOOR_W-1:0] car_floor,
    input wire logic [1:0]         motion_state,
    input wire logic [1:0]         step_action,
    input wire logic [FLOOR_W-1:0] chosen_target,
    input wire logic               target_valid,
    input wire logic               car_idle
);

    // a stalled result keeps its floor, motion state and step action
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(car_floor)
            && $stable(motion_state) && $stable(step_action))
        else $error("result changed while stalled");

    // any step needs a chosen target
    a_step_target: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && step_action != ACT_NONE |-> target_valid)
        else $error("step without target");

    // no target means target field reads zero
    a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !target_valid |-> chosen_target == '0)
        else $error("chosen target set without valid");

    // doors at the target floor means the car is there
    a_doors_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && step_action == ACT_DOORS |-> chosen_target == car_floor
            && motion_state == MOT_IDLE)
        else $error("doors opened away from target");

    // idle flag implies idle motion
    a_idle_motion: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && car_idle |-> motion_state == MOT_IDLE)
        else $error("car idle while moving");

endmodule : entc_checker

bind elevator_nearest_target_controller_top entc_checker u_entc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .car_floor     (car_floor),
    .motion_state  (motion_state),
    .step_action   (step_action),
    .chosen_target (chosen_target),
    .target_valid  (target_valid),
    .car_idle      (car_idle)
);
`default_nettype wire

// ----- test/elevator_nearest_target_controller_top_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// elevator_nearest_target_controller_top_tb
// self-checking bench for the nearest-target elevator controller: a status
// predictor tracks the car and the pending floors, and every output
// transaction is checked field by field against the oldest prediction while
// the sender works in bursts and the receiver stalls on patterns of its own
// ----------------------------------------------------------------------------
module elevator_nearest_target_controller_top_tb;
    import entc_pkg::*;

    // one output transaction as the block reports it
    typedef struct packed {
        logic [FLOOR_W-1:0] car_floor;
        logic [1:0]         motion_state;
        logic [1:0]         step_action;
        logic [FLOOR_W-1:0] chosen_target;
        logic               target_valid;
        logic               car_idle;
        logic               request_rejected;
        logic               is_running;
    } car_status_t;

    // ------------------------------------------------------------------------
    // status predictor and store of expected car status
    // ------------------------------------------------------------------------
    class car_status_board;
        logic [FLOOR_SLOTS-1:0] pending;
        logic [FLOOR_W-1:0]     floor_now;
        logic [1:0]             motion;
        logic                   running;
        car_status_t            expected_q[$];
        int unsigned            errors;

        function new();
            pending   = '0;
            floor_now = FLOOR_W'(RESET_FLOOR);
            motion    = MOT_IDLE;
            running   = 1'b0;
            errors    = 0;
        endfunction

        // advance the car by one input transaction and report its status
        function car_status_t next_car_status(logic [1:0] op, logic [FLOOR_W-1:0] flr);
            car_status_t        st;
            logic [FLOOR_W-1:0] tgt;
            int                 best_dist;
            int                 slot_dist;
            bit                 found;
            st          = '0;
            st.step_action = ACT_NONE;
            tgt         = '0;
            found       = 1'b0;
            best_dist   = FLOOR_SLOTS + 1;
            case (op)
                OP_REQUEST:
                begin
                    if (int'(flr) < NUM_FLOORS)
                        pending[flr] = 1'b1;
                    else
                        st.request_rejected = 1'b1;
                end
                OP_TICK:
                begin
                    if (running)
                    begin
                        // nearest pending floor, strict compare keeps the lowest on a tie
                        for (int f = 0; f < FLOOR_SLOTS; f++)
                        begin
                            if (pending[f])
                            begin
                                slot_dist = (f > int'(floor_now)) ? f - int'(floor_now)
                                                                  : int'(floor_now) - f;
                                if (slot_dist < best_dist)
                                begin
                                    best_dist = slot_dist;
                                    tgt       = FLOOR_W'(f);
                                    found     = 1'b1;
                                end
                            end
                        end
                    end
                    if (found)
                    begin
                        st.chosen_target = tgt;
                        st.target_valid  = 1'b1;
                        if (tgt == floor_now)
                        begin
                            pending[tgt]   = 1'b0;
                            motion         = MOT_IDLE;
                            st.step_action = ACT_DOORS;
                        end
                        else if (tgt > floor_now)
                        begin
                            motion         = MOT_UP;
                            floor_now      = floor_now + 1'b1;
                            st.step_action = ACT_UP;
                        end
                        else
                        begin
                            motion         = MOT_DOWN;
                            floor_now      = floor_now - 1'b1;
                            st.step_action = ACT_DOWN;
                        end
                        if (pending == '0)
                            motion = MOT_IDLE;
                    end
                end
                OP_STOP:
                    running = 1'b0;
                default:
                    running = 1'b1;
            endcase
            st.car_floor    = floor_now;
            st.motion_state = motion;
            st.car_idle     = (motion == MOT_IDLE) && (pending == '0);
            st.is_running   = running;
            return st;
        endfunction

        function void note_input(logic [1:0] op, logic [FLOOR_W-1:0] flr);
            expected_q.push_back(next_car_status(op, flr));
        endfunction

        function void compare(string name, int unsigned exp_val, int unsigned act_val);
            if (exp_val != act_val)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d actual %0d",
                         $time, name, exp_val, act_val);
            end
        endfunction

        function void check_result(car_status_t act);
            car_status_t exp_st;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output transaction, expected none actual %h",
                         $time, act);
                return;
            end
            exp_st = expected_q.pop_front();
            compare("car_floor",        exp_st.car_floor,        act.car_floor);
            compare("motion_state",     exp_st.motion_state,     act.motion_state);
            compare("step_action",      exp_st.step_action,      act.step_action);
            compare("chosen_target",    exp_st.chosen_target,    act.chosen_target);
            compare("target_valid",     exp_st.target_valid,     act.target_valid);
            compare("car_idle",         exp_st.car_idle,         act.car_idle);
            compare("request_rejected", exp_st.request_rejected, act.request_rejected);
            compare("is_running",       exp_st.is_running,       act.is_running);
        endfunction

        function int waiting();
            return expected_q.size();
        endfunction
    endclass

    // run length: random items, cycle limit and drain time after the last result
    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;

    // clock, reset and block inputs, all driven to known values from time zero
    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               in_ready;
    logic [1:0]         operation     = OP_REQUEST;
    logic [FLOOR_W-1:0] request_floor = '0;
    logic               out_valid;
    logic               out_ready     = 1'b0;
    logic [FLOOR_W-1:0] car_floor;
    logic [1:0]         motion_state;
    logic [1:0]         step_action;
    logic [FLOOR_W-1:0] chosen_target;
    logic               target_valid;
    logic               car_idle;
    logic               request_rejected;
    logic               is_running;

    car_status_board board = new();
    int unsigned     cycle_count = 0;
    int unsigned     burst_left  = 0;
    int unsigned     items_sent  = 0;

    elevator_nearest_target_controller_top i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .request_floor    (request_floor),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .car_floor        (car_floor),
        .motion_state     (motion_state),
        .step_action      (step_action),
        .chosen_target    (chosen_target),
        .target_valid     (target_valid),
        .car_idle         (car_idle),
        .request_rejected (request_rejected),
        .is_running       (is_running)
    );

    always #5 clk = ~clk;

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // input monitor: every accepted transaction advances the predictor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            board.note_input(operation, request_floor);
    end

    // output monitor: every accepted transaction is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result('{car_floor, motion_state, step_action, chosen_target,
                                 target_valid, car_idle, request_rejected, is_running});
    end

    // receiver back-pressure: a mode drawn at random sets the pattern
    // mode 0 never stalls, 1 is coin-flip, 2 is periodic, 3 holds long stalls
    int unsigned rx_mode  = 0;
    int unsigned rx_phase = 0;
    int unsigned rx_run   = 0;
    logic        rx_level = 1'b1;
    always @(posedge clk)
    begin
        rx_phase++;
        if (rx_phase % 256 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= (rx_phase % 8) < 3;
            default:
            begin
                if (rx_run == 0)
                begin
                    rx_level = ~rx_level;
                    rx_run   = rx_level ? $urandom_range(1, 6) : $urandom_range(1, 12);
                end
                rx_run--;
                out_ready <= rx_level;
            end
        endcase
    end

    // drive one input transaction, hold it until accepted, then maybe pause
    // the sender between bursts; called at a rising edge
    task automatic send_item(input logic [1:0] op, input logic [FLOOR_W-1:0] flr);
        operation     <= op;
        request_floor <= flr;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        if (burst_left == 0)
        begin
            // occasionally run straight into the next burst with no gap at all
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 25)) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
        else
            burst_left--;
    endtask

    // random operation with random floor, including ops that ignore the floor
    task automatic send_noise();
        logic [1:0] op;
        case ($urandom_range(0, 3))
            0: op = OP_REQUEST;
            1: op = OP_TICK;
            2: op = OP_STOP;
            default: op = OP_START;
        endcase
        send_item(op, FLOOR_W'($urandom_range(0, FLOOR_SLOTS - 1)));
    endtask

    // a trip: optional start, a few floor calls, then a run of ticks that
    // usually reaches the targets, now and then interrupted by a stop
    task automatic send_trip();
        int unsigned n_calls;
        int unsigned n_ticks;
        if ($urandom_range(0, 1) == 0)
            send_item(OP_START, FLOOR_W'($urandom_range(0, FLOOR_SLOTS - 1)));
        n_calls = $urandom_range(1, 3);
        repeat (n_calls)
            send_item(OP_REQUEST, FLOOR_W'($urandom_range(0, FLOOR_SLOTS - 1)));
        n_ticks = $urandom_range(1, 24);
        repeat (n_ticks)
        begin
            if ($urandom_range(0, 29) == 0)
            begin
                send_item(OP_STOP, FLOOR_W'($urandom_range(0, FLOOR_SLOTS - 1)));
                send_item(OP_TICK, FLOOR_W'($urandom_range(0, FLOOR_SLOTS - 1)));
                send_item(OP_START, FLOOR_W'($urandom_range(0, FLOOR_SLOTS - 1)));
            end
            send_item(OP_TICK, FLOOR_W'($urandom_range(0, FLOOR_SLOTS - 1)));
        end
    endtask

    initial
    begin
        // reset held low, then released at a rising edge
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: tick while stopped with nothing pending
        send_item(OP_TICK, 4'd9);
        // request for the current floor and a plain request while stopped
        send_item(OP_REQUEST, 4'd0);
        send_item(OP_REQUEST, 4'd3);
        // duplicate request
        send_item(OP_REQUEST, 4'd3);
        // tick while stopped with work pending
        send_item(OP_TICK, 4'd0);
        send_item(OP_START, 4'd0);
        // doors at the current floor, then climb toward floor 3
        send_item(OP_TICK, 4'd0);
        send_item(OP_TICK, 4'd15);
        send_item(OP_TICK, 4'd0);
        // stop mid-trip keeps the motion, a tick does nothing
        send_item(OP_STOP, 4'd15);
        send_item(OP_TICK, 4'd0);
        send_item(OP_START, 4'd15);
        send_item(OP_TICK, 4'd0);
        send_item(OP_TICK, 4'd0);
        // running tick with nothing pending
        send_item(OP_TICK, 4'd0);
        // tie at equal distance: the lower floor wins
        send_item(OP_REQUEST, 4'd5);
        send_item(OP_REQUEST, 4'd1);
        send_item(OP_TICK, 4'd0);
        send_item(OP_TICK, 4'd0);
        send_item(OP_TICK, 4'd0);
        // top and bottom floors pending, descend to the bottom one
        send_item(OP_REQUEST, 4'd15);
        send_item(OP_REQUEST, 4'd0);
        send_item(OP_TICK, 4'd0);
        send_item(OP_TICK, 4'd0);

        // random: mostly well-formed trips, the rest noise
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 7)
                send_trip();
            else
                repeat ($urandom_range(1, 6)) send_noise();
        end

        // drain: wait for every predicted transaction, then a little longer
        in_valid <= 1'b0;
        while (board.waiting() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule : elevator_nearest_target_controller_top_tb
`default_nettype wire

// ----- sim.f -----
rtl/entc_pkg.sv
rtl/entc_ctrl.sv
rtl/entc_datapath.sv
rtl/elevator_nearest_target_controller_top.sv
rtl/entc_checker.sv
test/elevator_nearest_target_controller_top_tb.sv
